// ===== sv/ftpc_pkg.sv =====
// Shared types and constants for the flow tuple packet counter.
// Used by every module of the block; no dependencies.
package ftpc_pkg;

    localparam int TABLE_ENTRIES   = 64;
    localparam int IDX_W           = $clog2(TABLE_ENTRIES);
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES) + 1;
    localparam int MIN_FRAME_BYTES = 42;
    localparam int MAC_HDR_BYTES   = 14;
    localparam int SRC_START       = MAC_HDR_BYTES + 12;
    localparam int DST_START       = MAC_HDR_BYTES + 16;
    localparam int PORTS_START     = MAC_HDR_BYTES + 20;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_NEW   = 3'd1,
        ST_FULL  = 3'd2,
        ST_SHORT = 3'd3,
        ST_READ  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } t_seq_state;

    // ports: source port in [31:16], destination port in [15:0]
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] ports;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [31:0] count;
    } t_entry;

    typedef struct packed {
        t_key key;
        logic short_frame;
    } t_cap;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_tbl_req;

    typedef struct packed {
        logic   valid;
        t_entry data;
    } t_tbl_rsp;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic             valid;
        t_entry           entry;
    } t_result;

endpackage

// ===== sv/ftpc_capture.sv =====
// Frame byte counter and header key capture (IPv4 addresses and ports).
// Depends on ftpc_pkg.
module ftpc_capture
    import ftpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_en,
    input  logic [7:0] i_byte,
    input  logic       i_clear,
    output t_cap       o_cap
);

    logic [POS_W-1:0] r_pos, n_pos;
    t_key             r_key, n_key;

    always_comb begin
        n_pos = r_pos;
        n_key = r_key;
        if (i_clear) begin
            n_pos = '0;
            n_key = '0;
        end else if (i_byte_en && (r_pos < POS_W'(MAX_FRAME_BYTES))) begin
            if ((r_pos >= POS_W'(SRC_START)) && (r_pos < POS_W'(SRC_START + 4))) begin
                n_key.src = {r_key.src[23:0], i_byte};
            end else if ((r_pos >= POS_W'(DST_START)) && (r_pos < POS_W'(DST_START + 4))) begin
                n_key.dst = {r_key.dst[23:0], i_byte};
            end else if ((r_pos >= POS_W'(PORTS_START))
                         && (r_pos < POS_W'(PORTS_START + 4))) begin
                n_key.ports = {r_key.ports[23:0], i_byte};
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_key <= '0;
        end else begin
            r_pos <= n_pos;
            r_key <= n_key;
        end
    end

    assign o_cap.key         = r_key;
    assign o_cap.short_frame = (r_pos < POS_W'(MIN_FRAME_BYTES));

endmodule

// ===== sv/ftpc_table.sv =====
// Flow table: entry memory with one write and one registered read port,
// plus per-entry valid flops cleared at reset. Depends on ftpc_pkg.
module ftpc_table
    import ftpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_tbl_rsp o_rsp
);

    t_entry                   r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry                   r_rd_data;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rsp.valid = r_rd_valid;
    assign o_rsp.data  = r_rd_data;

endmodule

// ===== sv/ftpc_seq.sv =====
// Sequencer: handshakes, table scan with shared key compare and saturating
// count increment, result and output registers. Depends on ftpc_pkg.
module ftpc_seq
    import ftpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_opcode,
    input  logic             i_frame_last,
    input  logic [IDX_W-1:0] i_read_index,
    input  t_cap             i_cap,
    output logic             o_byte_en,
    output logic             o_cap_clear,
    output t_tbl_req         o_req,
    input  t_tbl_rsp         i_rsp,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_result
);

    t_seq_state       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic             r_free_found, n_free_found;
    t_result          r_res, n_res;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             hit;
    logic [31:0]      cnt_inc;

    assign hit     = i_rsp.valid && (i_rsp.data.key == i_cap.key);
    assign cnt_inc = (i_rsp.data.count == 32'hFFFF_FFFF) ? i_rsp.data.count
                                                         : i_rsp.data.count + 32'd1;

    assign o_ready   = (r_state == S_IDLE);
    assign o_byte_en = o_ready && i_valid && (i_opcode == OP_BYTE);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_free_idx   = r_free_idx;
        n_free_found = r_free_found;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_ready;
        o_req        = '0;
        o_cap_clear  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == OP_READ) begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = i_read_index;
                        n_res.index   = i_read_index;
                        n_state       = S_RD_WAIT;
                    end else if (i_frame_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_RD_WAIT: begin
                n_res.status = ST_READ;
                n_res.valid  = i_rsp.valid;
                n_res.entry  = i_rsp.valid ? i_rsp.data : '0;
                n_state      = S_EMIT;
            end
            S_CHECK: begin
                if (i_cap.short_frame) begin
                    n_res        = '0;
                    n_res.status = ST_SHORT;
                    o_cap_clear  = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = '0;
                    n_idx         = '0;
                    n_free_found  = 1'b0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                // read data of entry r_idx is on i_rsp this cycle
                if (hit) begin
                    o_req.wr_en               = 1'b1;
                    o_req.wr_addr             = r_idx;
                    o_req.wr_data.key         = i_rsp.data.key;
                    o_req.wr_data.count       = cnt_inc;
                    n_res.status              = ST_HIT;
                    n_res.index               = r_idx;
                    n_res.valid               = 1'b1;
                    n_res.entry.key           = i_rsp.data.key;
                    n_res.entry.count         = cnt_inc;
                    o_cap_clear               = 1'b1;
                    n_state                   = S_EMIT;
                end else begin
                    if (!i_rsp.valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_idx         = r_idx + IDX_W'(1);
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = r_idx + IDX_W'(1);
                    end
                end
            end
            S_DECIDE: begin
                if (r_free_found) begin
                    o_req.wr_en         = 1'b1;
                    o_req.wr_addr       = r_free_idx;
                    o_req.wr_data.key   = i_cap.key;
                    o_req.wr_data.count = 32'd1;
                    n_res.status        = ST_NEW;
                    n_res.index         = r_free_idx;
                    n_res.valid         = 1'b1;
                    n_res.entry.count   = 32'd1;
                end else begin
                    n_res.status      = ST_FULL;
                    n_res.index       = '0;
                    n_res.valid       = 1'b0;
                    n_res.entry.count = '0;
                end
                n_res.entry.key = i_cap.key;
                o_cap_clear     = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_free_found <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_free_found <= n_free_found;
            r_idx        <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== sv/flow_tuple_packet_counter.sv =====
// Top level of the flow tuple packet counter: capture, flow table, sequencer.
// Depends on ftpc_pkg, ftpc_capture, ftpc_table, ftpc_seq.
//
// Frames arrive one byte per transaction; a frame byte that is not the last
// is taken without leaving the idle state and gives no result. On the last
// byte the block checks the frame length and then scans the 64-entry flow
// table one entry per cycle through the single registered read port,
// comparing the captured IPv4 address/port key and counting (saturating) on
// a hit or filling the lowest free entry on a miss. A last byte holds the
// block for the length check and, on a long enough frame, for the scan,
// which ends at the first hit or after the last entry; a read holds it for
// the table read. Ready is low while a transaction is in work. One result
// register sits on the output, so new transactions are taken while a result
// waits; a second result holds the block in its final cycle until the waiting
// one is taken. The valid marks are cleared by reset, with no clearing pass.
module flow_tuple_packet_counter
    import ftpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic [5:0]  i_read_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_entry_index,
    output logic        o_entry_valid,
    output logic [31:0] o_src_address,
    output logic [15:0] o_src_port_number,
    output logic [31:0] o_dst_address,
    output logic [15:0] o_dst_port_number,
    output logic [31:0] o_packet_count
);

    t_cap     cap;
    t_tbl_req req;
    t_tbl_rsp rsp;
    t_result  res;
    logic     byte_en;
    logic     cap_clear;

    ftpc_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte_en(byte_en),
        .i_byte   (i_frame_byte),
        .i_clear  (cap_clear),
        .o_cap    (cap)
    );

    ftpc_table u_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    ftpc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_frame_last(i_frame_last),
        .i_read_index(i_read_index),
        .i_cap       (cap),
        .o_byte_en   (byte_en),
        .o_cap_clear (cap_clear),
        .o_req       (req),
        .i_rsp       (rsp),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (res)
    );

    assign o_status          = res.status;
    assign o_entry_index     = res.index;
    assign o_entry_valid     = res.valid;
    assign o_src_address     = res.entry.key.src;
    assign o_dst_address     = res.entry.key.dst;
    assign o_src_port_number = res.entry.key.ports[31:16];
    assign o_dst_port_number = res.entry.key.ports[15:0];
    assign o_packet_count    = res.entry.count;

endmodule

// ===== sv/ftpc_checker.sv =====
// Port-level checks for the flow tuple packet counter, bound to the top level.
// Depends on ftpc_pkg and flow_tuple_packet_counter.
module ftpc_checker
    import ftpc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_opcode,
    input logic        i_frame_last,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [5:0]  o_entry_index,
    input logic        o_entry_valid,
    input logic [31:0] o_packet_count
);

    // a result stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transaction");

    // the last byte of a frame always starts a search or length check
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_opcode == OP_BYTE) && i_frame_last |=> !o_ready)
        else $error("ready right after last byte");

    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NEW) |-> o_entry_valid && (o_packet_count == 32'd1))
        else $error("new flow without count of one");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_HIT) |-> o_entry_valid && (o_packet_count >= 32'd2))
        else $error("hit with bad count");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_status == ST_FULL) || (o_status == ST_SHORT))
        |-> !o_entry_valid && (o_entry_index == '0) && (o_packet_count == '0))
        else $error("dropped frame reports an entry");

endmodule

bind flow_tuple_packet_counter ftpc_checker u_ftpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_opcode      (i_opcode),
    .i_frame_last  (i_frame_last),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_entry_index (o_entry_index),
    .o_entry_valid (o_entry_valid),
    .o_packet_count(o_packet_count)
);

// ===== bench/flow_tuple_packet_counter_tb.sv =====
// Testbench for flow_tuple_packet_counter: directed and random frame traffic,
// table reads, output stalls and table overflow, checked against a local predictor.
// Depends on ftpc_pkg and the flow_tuple_packet_counter RTL.
module flow_tuple_packet_counter_tb;
    import ftpc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int DRAIN_CYCLES = 100;
    localparam int TIMEOUT      = 3_000_000;
    localparam int POOL_KEYS    = 6;
    localparam int REPORT_LIMIT = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_opcode;
    logic [7:0]  i_frame_byte;
    logic        i_frame_last;
    logic [5:0]  i_read_index;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [5:0]  o_entry_index;
    logic        o_entry_valid;
    logic [31:0] o_src_address;
    logic [15:0] o_src_port_number;
    logic [31:0] o_dst_address;
    logic [15:0] o_dst_port_number;
    logic [31:0] o_packet_count;

    flow_tuple_packet_counter i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_frame_byte      (i_frame_byte),
        .i_frame_last      (i_frame_last),
        .i_read_index      (i_read_index),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_entry_index     (o_entry_index),
        .o_entry_valid     (o_entry_valid),
        .o_src_address     (o_src_address),
        .o_src_port_number (o_src_port_number),
        .o_dst_address     (o_dst_address),
        .o_dst_port_number (o_dst_port_number),
        .o_packet_count    (o_packet_count)
    );

    // predicted flow table and frame capture
    logic [11:0] cap_pos;
    t_key        cap_key;
    t_entry      flow_tbl [TABLE_ENTRIES];
    logic        flow_used [TABLE_ENTRIES];
    int          flows_used_cnt;

    t_result     pending_results [$];
    t_key        key_pool [POOL_KEYS];

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;
    int items_sent;
    int results_seen;
    int mismatch_count;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT;
        $display("Test completed with failures");
        $finish;
    end

    // Updates the predicted table for one accepted transaction and queues
    // the result it should produce, if any.
    function automatic void predict_flow_update(input logic op, input logic [7:0] b,
                                                input logic frame_last,
                                                input logic [5:0] ridx);
        t_result r;
        int      pos;
        int      hit;
        int      free_slot;
        r = '0;
        if (op == OP_READ) begin
            r.status = ST_READ;
            r.index  = ridx;
            if (flow_used[ridx]) begin
                r.valid = 1'b1;
                r.entry = flow_tbl[ridx];
            end
            pending_results.push_back(r);
            return;
        end
        if (cap_pos < MAX_FRAME_BYTES) begin
            pos = cap_pos;
            if (pos >= SRC_START && pos < SRC_START + 4)
                cap_key.src = {cap_key.src[23:0], b};
            else if (pos >= DST_START && pos < DST_START + 4)
                cap_key.dst = {cap_key.dst[23:0], b};
            else if (pos >= PORTS_START && pos < PORTS_START + 4)
                cap_key.ports = {cap_key.ports[23:0], b};
            cap_pos = cap_pos + 12'd1;
        end
        if (!frame_last)
            return;
        if (cap_pos < MIN_FRAME_BYTES) begin
            r.status = ST_SHORT;
        end else begin
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (hit < 0 && flow_used[i] && flow_tbl[i].key == cap_key)
                    hit = i;
                if (free_slot < 0 && !flow_used[i])
                    free_slot = i;
            end
            if (hit >= 0) begin
                if (flow_tbl[hit].count != 32'hFFFF_FFFF)
                    flow_tbl[hit].count = flow_tbl[hit].count + 32'd1;
                r.status = ST_HIT;
                r.index  = IDX_W'(hit);
                r.valid  = 1'b1;
                r.entry  = flow_tbl[hit];
            end else if (free_slot >= 0) begin
                flow_used[free_slot]      = 1'b1;
                flow_tbl[free_slot].key   = cap_key;
                flow_tbl[free_slot].count = 32'd1;
                flows_used_cnt++;
                r.status = ST_NEW;
                r.index  = IDX_W'(free_slot);
                r.valid  = 1'b1;
                r.entry  = flow_tbl[free_slot];
            end else begin
                r.status    = ST_FULL;
                r.entry.key = cap_key;
            end
        end
        pending_results.push_back(r);
        cap_pos = '0;
        cap_key = '0;
    endfunction

    function automatic t_key random_key();
        return {$urandom, $urandom, $urandom};
    endfunction

    // entries are never invalidated, so only written entries are read
    function automatic logic [5:0] pick_used_index();
        int start;
        int idx;
        start = $urandom_range(TABLE_ENTRIES - 1);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            idx = (start + i) % TABLE_ENTRIES;
            if (flow_used[idx])
                return 6'(idx);
        end
        return '0;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v)
            note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, exp_v, act_v));
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic op, input logic [7:0] b, input logic frame_last,
                             input logic [5:0] ridx);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_opcode     = op;
        i_frame_byte = b;
        i_frame_last = frame_last;
        i_read_index = ridx;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_flow_update(op, b, frame_last, ridx);
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Sends one frame carrying key k; read_pct mixes table reads between bytes.
    task automatic send_frame(input t_key k, input int len, input int read_pct);
        logic [7:0] b;
        for (int p = 0; p < len; p++) begin
            if (p >= SRC_START && p < SRC_START + 4)
                b = k.src[8*(SRC_START+3-p) +: 8];
            else if (p >= DST_START && p < DST_START + 4)
                b = k.dst[8*(DST_START+3-p) +: 8];
            else if (p >= PORTS_START && p < PORTS_START + 4)
                b = k.ports[8*(PORTS_START+3-p) +: 8];
            else
                b = 8'($urandom);
            if (flows_used_cnt > 0 && $urandom_range(99) < read_pct)
                send_item(OP_READ, 8'($urandom), 1'($urandom), pick_used_index());
            send_item(OP_BYTE, b, p == len - 1, 6'($urandom));
        end
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_short_frames();
        send_frame(key_pool[1], 1, 0);
        send_frame(random_key(), MIN_FRAME_BYTES - 1, 0);
    endtask

    task automatic test_new_and_hit();
        send_frame(key_pool[0], MIN_FRAME_BYTES, 0);
        send_frame(key_pool[1], MIN_FRAME_BYTES, 0);
        send_frame(key_pool[1], MIN_FRAME_BYTES + 1, 0);
        send_item(OP_READ, 8'hFF, 1'b1, 6'd0);
        send_item(OP_READ, 8'h00, 1'b0, 6'd1);
    endtask

    task automatic test_read_during_frame();
        send_frame(key_pool[2], 50, 30);
        send_frame(key_pool[2], MIN_FRAME_BYTES, 50);
    endtask

    // bytes past the capture limit are dropped but the frame still ends
    task automatic test_long_frame();
        send_frame(key_pool[0], MAX_FRAME_BYTES + 5, 0);
    endtask

    task automatic test_random_traffic(input int item_goal, input int result_goal);
        int   start_items;
        int   start_results;
        int   pick;
        int   len;
        t_key k;
        start_items   = items_sent;
        start_results = results_seen;
        while (items_sent - start_items < item_goal ||
               results_seen - start_results < result_goal) begin
            pick = $urandom_range(99);
            if (pick < 15 && flows_used_cnt > 0) begin
                send_item(OP_READ, 8'($urandom), 1'($urandom), pick_used_index());
            end else if (pick < 25) begin
                send_frame(random_key(), $urandom_range(1, MIN_FRAME_BYTES - 1), 5);
            end else begin
                k = ($urandom_range(99) < 60) ? key_pool[$urandom_range(POOL_KEYS - 1)]
                                              : random_key();
                len = ($urandom_range(99) < 5) ? $urandom_range(61, 200)
                                               : $urandom_range(MIN_FRAME_BYTES, 60);
                send_frame(k, len, 5);
            end
        end
    endtask

    // receiver held off while reads keep coming, so the input stalls
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        for (int n = 0; n < 8; n++)
            send_item(OP_READ, 8'($urandom), 1'($urandom), pick_used_index());
        send_frame(key_pool[3], MIN_FRAME_BYTES, 0);
        wait_for_results();
        send_frame(key_pool[3], MIN_FRAME_BYTES, 0);
    endtask

    task automatic test_table_full();
        while (flows_used_cnt < TABLE_ENTRIES)
            send_frame(random_key(), MIN_FRAME_BYTES, 0);
        repeat (3)
            send_frame(random_key(), MIN_FRAME_BYTES + $urandom_range(8), 2);
        // known flows still count once the table is full
        send_frame(key_pool[1], MIN_FRAME_BYTES, 0);
        send_frame(random_key(), 10, 0);
    endtask

    task automatic test_read_all_entries();
        for (int n = 0; n < TABLE_ENTRIES; n++)
            send_item(OP_READ, 8'($urandom), 1'($urandom), 6'(n));
        repeat (64)
            send_item(OP_READ, 8'($urandom), 1'($urandom), 6'($urandom));
    endtask

    // receiver side: random stalls, or a counted hold-off when requested
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_ready = 1'b0;
                rx_hold_cycles--;
            end else begin
                i_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result: status %0d index %0d",
                                       o_status, o_entry_index));
            end else begin
                exp_r = pending_results.pop_front();
                compare_field("status", 32'(exp_r.status), 32'(o_status));
                compare_field("entry_index", 32'(exp_r.index), 32'(o_entry_index));
                compare_field("entry_valid", 32'(exp_r.valid), 32'(o_entry_valid));
                compare_field("src_address", exp_r.entry.key.src, o_src_address);
                compare_field("src_port_number", 32'(exp_r.entry.key.ports[31:16]),
                              32'(o_src_port_number));
                compare_field("dst_address", exp_r.entry.key.dst, o_dst_address);
                compare_field("dst_port_number", 32'(exp_r.entry.key.ports[15:0]),
                              32'(o_dst_port_number));
                compare_field("packet_count", exp_r.entry.count, o_packet_count);
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = OP_BYTE;
        i_frame_byte   = '0;
        i_frame_last   = 1'b0;
        i_read_index   = '0;
        cap_pos        = '0;
        cap_key        = '0;
        flows_used_cnt = 0;
        rx_hold_cycles = 0;
        items_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            flow_used[i] = 1'b0;
            flow_tbl[i]  = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = random_key();
        tx_idle_pct = 19;
        rx_idle_pct = 67;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_frames();
        test_new_and_hit();
        test_read_during_frame();
        test_long_frame();
        test_random_traffic(200, 16);

        tx_idle_pct = 67;
        rx_idle_pct = 19;
        test_random_traffic(200, 16);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(200, 16);
        test_backpressure();
        test_table_full();
        test_read_all_entries();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
